FILE: rtl/msma_pkg.sv
// Shared types, constants and helpers for the multichannel sensor moving average.
// Used by the controller, the datapath, the top level and the testbench; depends on nothing else.
`default_nettype none
package msma_pkg;

	localparam int WINDOW_DEF   = 8;
	localparam int CHANNELS_DEF = 7;

	localparam int CH_W    = 3;
	localparam int RAW_W   = 16;
	localparam int GAIN_W  = 24;
	localparam int Q_W     = 24;
	localparam int PROD_W  = RAW_W + GAIN_W + 1;
	localparam int FRAC_SHIFT = 16;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	localparam logic signed [PROD_W-1:0] Q_MAX_W = PROD_W'(8388607);
	localparam logic signed [PROD_W-1:0] Q_MIN_W = -PROD_W'(8388608);
	localparam logic signed [PROD_W-1:0] ROUND_HALF_W = PROD_W'(32768);

	localparam logic [CH_W-1:0] CH_GYRO_FIRST = 3'd3;
	localparam logic [CH_W-1:0] CH_TEMP       = 3'd6;
	localparam logic [CH_W-1:0] CH_NONE       = 3'd7;

	localparam logic [1:0] REG_ACCEL_GAIN  = 2'd0;
	localparam logic [1:0] REG_GYRO_GAIN   = 2'd1;
	localparam logic [1:0] REG_TEMP_GAIN   = 2'd2;
	localparam logic [1:0] REG_TEMP_OFFSET = 2'd3;

	localparam logic [GAIN_W-1:0] ACCEL_GAIN_RST  = 24'd262079;
	localparam logic [GAIN_W-1:0] GYRO_GAIN_RST   = 24'd4574140;
	localparam logic [GAIN_W-1:0] TEMP_GAIN_RST   = 24'd13142495;
	localparam logic [Q_W-1:0]    TEMP_OFFSET_RST = 24'd1638400;

	typedef struct packed {
		logic [GAIN_W-1:0]     accel_gain;
		logic [GAIN_W-1:0]     gyro_gain;
		logic [GAIN_W-1:0]     temp_gain;
		logic signed [Q_W-1:0] temp_offset;
	} msma_cfg_t;

	typedef struct packed {
		logic capture;
		logic mul;
		logic rnd;
		logic ofs;
		logic upd;
		logic dstart;
		logic load_out;
	} msma_cmd_t;

	typedef struct packed {
		logic ch_ok;
		logic div_done;
	} msma_sts_t;

	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > Q_MAX_W) begin
			r = Q_W'(Q_MAX_W);
		end else if (v < Q_MIN_W) begin
			r = Q_W'(Q_MIN_W);
		end else begin
			r = Q_W'(v);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/msma_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; used by the datapath for the per-channel sample rings.
`default_nettype none
module msma_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 56
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/msma_div.sv
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating toward zero.
// Stand-alone; used by the datapath to divide a running sum by its fill count.
`default_nettype none
module msma_div #(
	parameter int DIVD_W = 27,
	parameter int DIVS_W = 4
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     start,
	input  wire logic signed [DIVD_W-1:0] dividend,
	input  wire logic [DIVS_W-1:0]        divisor,
	output logic                          done,
	output logic signed [DIVD_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] quo_q;
	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] div_q;
	logic              neg_q;
	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DIVS_W:0]   trial;
	logic              ge;
	logic [DIVS_W:0]   rem_next;
	logic [DIVD_W-1:0] mag;

	assign mag      = dividend[DIVD_W-1] ? DIVD_W'(-dividend) : DIVD_W'(dividend);
	assign trial    = {rem_q, quo_q[DIVD_W-1]};
	assign ge       = trial >= {1'b0, div_q};
	assign rem_next = ge ? (trial - {1'b0, div_q}) : trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == STEP_W'(DIVD_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(DIVD_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= mag;
			rem_q <= '0;
			div_q <= divisor;
			neg_q <= dividend[DIVD_W-1];
		end else if (busy_q) begin
			quo_q <= {quo_q[DIVD_W-2:0], ge};
			rem_q <= rem_next[DIVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
`default_nettype wire

FILE: rtl/msma_ctrl.sv
// Controller state machine: sequences scale, ring update, divide and result hand-off.
// Depends on msma_pkg for the command and status types.
`default_nettype none
module msma_ctrl import msma_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire msma_sts_t sts,
	output msma_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_RND,
		S_OFS,
		S_UPD,
		S_DSTART,
		S_DIV,
		S_OUT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd          = '0;
		cmd.capture  = in_valid && (state_q == S_IDLE);
		cmd.mul      = state_q == S_MUL;
		cmd.rnd      = state_q == S_RND;
		cmd.ofs      = state_q == S_OFS;
		cmd.upd      = state_q == S_UPD;
		cmd.dstart   = state_q == S_DSTART;
		cmd.load_out = (state_q == S_OUT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && sts.ch_ok) begin
						state_q <= S_MUL;
					end
				end
				S_MUL:    state_q <= S_RND;
				S_RND:    state_q <= S_OFS;
				S_OFS:    state_q <= S_UPD;
				S_UPD:    state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: begin
					if (sts.div_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: rtl/msma_dp.sv
// Datapath: gain scaling with rounding and saturation, per-channel ring, sum and fill count.
// Depends on msma_pkg, msma_ram and msma_div.
`default_nettype none
module msma_dp import msma_pkg::*; #(
	parameter int WINDOW   = WINDOW_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire msma_cmd_t              cmd,
	output msma_sts_t                   sts,
	input  wire msma_cfg_t              cfg,
	input  wire logic [CH_W-1:0]        channel,
	input  wire logic signed [RAW_W-1:0] raw_sample,
	output logic [CH_W-1:0]             out_channel,
	output logic signed [Q_W-1:0]       filtered_value
);

	localparam int SUM_W    = Q_W + $clog2(WINDOW);
	localparam int POS_W    = $clog2(WINDOW);
	localparam int CNT_W    = $clog2(WINDOW + 1);
	localparam int DEPTH    = CHANNELS * WINDOW;
	localparam int ADDR_W   = $clog2(DEPTH);
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	logic [CH_W-1:0]            ch_q;
	logic signed [RAW_W-1:0]    raw_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [Q_W-1:0]      scaled_q;
	logic signed [SUM_W-1:0]    sum_q [CHANNELS];
	logic [POS_W-1:0]           pos_q [CHANNELS];
	logic [CNT_W-1:0]           fill_q [CHANNELS];
	logic [CH_W-1:0]            out_channel_q;
	logic signed [Q_W-1:0]      filtered_q;

	logic [CH_IDX_W-1:0]        idx;
	logic [GAIN_W-1:0]          gain;
	logic signed [PROD_W-1:0]   rnd_sum;
	logic signed [PROD_W-1:0]   rnd_shift;
	logic signed [PROD_W-1:0]   ofs_sum;
	logic [ADDR_W-1:0]          addr;
	logic [Q_W-1:0]             rd_data;
	logic                       full;
	logic signed [SUM_W-1:0]    old_val;
	logic signed [SUM_W-1:0]    new_sum;
	logic signed [SUM_W-1:0]    quotient;
	logic                       div_done;

	assign idx = CH_IDX_W'(ch_q);

	always_comb begin
		if (ch_q < CH_GYRO_FIRST) begin
			gain = cfg.accel_gain;
		end else if (ch_q < CH_TEMP) begin
			gain = cfg.gyro_gain;
		end else begin
			gain = cfg.temp_gain;
		end
	end

	assign rnd_sum   = prod_q + ROUND_HALF_W;
	assign rnd_shift = rnd_sum >>> FRAC_SHIFT;
	assign ofs_sum   = PROD_W'(scaled_q) + PROD_W'(cfg.temp_offset);

	assign addr    = ADDR_W'(idx) * ADDR_W'(WINDOW) + ADDR_W'(pos_q[idx]);
	assign full    = fill_q[idx] == CNT_W'(WINDOW);
	assign old_val = full ? SUM_W'($signed(rd_data)) : '0;
	assign new_sum = sum_q[idx] - old_val + SUM_W'(scaled_q);

	assign sts.ch_ok    = (channel != CH_NONE) && (int'(channel) < CHANNELS);
	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q  <= channel;
			raw_q <= raw_sample;
		end
		if (cmd.mul) begin
			prod_q <= raw_q * $signed({1'b0, gain});
		end
		if (cmd.rnd) begin
			scaled_q <= sat_q(rnd_shift);
		end else if (cmd.ofs && (ch_q == CH_TEMP)) begin
			scaled_q <= sat_q(ofs_sum);
		end
		if (cmd.load_out) begin
			out_channel_q <= ch_q;
			filtered_q    <= Q_W'(quotient);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				sum_q[i]  <= '0;
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (cmd.upd) begin
			sum_q[idx] <= new_sum;
			pos_q[idx] <= (pos_q[idx] == POS_W'(WINDOW - 1)) ? '0 : pos_q[idx] + 1'b1;
			if (!full) begin
				fill_q[idx] <= fill_q[idx] + 1'b1;
			end
		end
	end

	msma_ram #(
		.WIDTH(Q_W),
		.DEPTH(DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (cmd.upd),
		.waddr(addr),
		.wdata(scaled_q),
		.re   (cmd.mul),
		.raddr(addr),
		.rdata(rd_data)
	);

	msma_div #(
		.DIVD_W(SUM_W),
		.DIVS_W(CNT_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.dstart),
		.dividend(sum_q[idx]),
		.divisor (fill_q[idx]),
		.done    (div_done),
		.quotient(quotient)
	);

	assign out_channel    = out_channel_q;
	assign filtered_value = filtered_q;

endmodule
`default_nettype wire

FILE: rtl/multichannel_sensor_moving_average.sv
// Top level of the multichannel sensor moving average with its APB register file.
// Depends on msma_pkg, msma_ctrl and msma_dp.
//
//   Port group   Direction  Handshake            Payload
//   input        in         in_valid/in_ready    channel, raw_sample
//   result       out        out_valid/out_ready  out_channel, filtered_value
//   registers    in/out     psel/penable/pready  paddr, pwdata, prdata
//
// Each result is formed by the one-bit-per-cycle divider that computes sum / fill count.
// One item is in work at a time; the next is taken once the previous result is in the
// output register. Reset clears all ring state at once through the fill counts.
// A stalled result holds the finished item in the output state until it is taken.
`default_nettype none
module multichannel_sensor_moving_average import msma_pkg::*; #(
	parameter int WINDOW   = WINDOW_DEF,
	parameter int CHANNELS = CHANNELS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [APB_AW-1:0]       paddr,
	input  wire logic [APB_DW-1:0]       pwdata,
	output logic      [APB_DW-1:0]       prdata,
	output logic                         pready,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [CH_W-1:0]         channel,
	input  wire logic signed [RAW_W-1:0] raw_sample,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic [CH_W-1:0]              out_channel,
	output logic signed [Q_W-1:0]        filtered_value
);

	msma_cfg_t cfg_q;
	msma_cmd_t cmd;
	msma_sts_t sts;
	logic      wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_gain  <= ACCEL_GAIN_RST;
			cfg_q.gyro_gain   <= GYRO_GAIN_RST;
			cfg_q.temp_gain   <= TEMP_GAIN_RST;
			cfg_q.temp_offset <= TEMP_OFFSET_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_ACCEL_GAIN:  cfg_q.accel_gain  <= pwdata[GAIN_W-1:0];
				REG_GYRO_GAIN:   cfg_q.gyro_gain   <= pwdata[GAIN_W-1:0];
				REG_TEMP_GAIN:   cfg_q.temp_gain   <= pwdata[GAIN_W-1:0];
				REG_TEMP_OFFSET: cfg_q.temp_offset <= pwdata[Q_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ACCEL_GAIN:  prdata = APB_DW'(cfg_q.accel_gain);
			REG_GYRO_GAIN:   prdata = APB_DW'(cfg_q.gyro_gain);
			REG_TEMP_GAIN:   prdata = APB_DW'(cfg_q.temp_gain);
			REG_TEMP_OFFSET: prdata = APB_DW'(unsigned'(cfg_q.temp_offset));
			default:         prdata = '0;
		endcase
	end

	msma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	msma_dp #(
		.WINDOW  (WINDOW),
		.CHANNELS(CHANNELS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg           (cfg_q),
		.channel       (channel),
		.raw_sample    (raw_sample),
		.out_channel   (out_channel),
		.filtered_value(filtered_value)
	);

endmodule
`default_nettype wire

FILE: dv/tb_multichannel_sensor_moving_average.sv
// Self-checking testbench for multichannel_sensor_moving_average: random and directed samples
// against a cycle-free boxcar predictor, with APB gain and offset changes between phases.
// Depends on msma_pkg and the RTL top level only.
`default_nettype none
module tb_multichannel_sensor_moving_average;
	timeunit 1ns;
	timeprecision 1ps;
	import msma_pkg::*;

	localparam int CYCLE_LIMIT = 900000;
	localparam int DRAIN_CYCLES = 80;
	localparam int RANDOM_PER_PHASE = 275;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic [CH_W-1:0]         ch;
		logic signed [RAW_W-1:0] raw;
	} sample_t;

	typedef struct {
		logic [CH_W-1:0]       ch;
		logic signed [Q_W-1:0] avg;
	} average_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    psel = 1'b0;
	logic                    penable = 1'b0;
	logic                    pwrite = 1'b0;
	logic [APB_AW-1:0]       paddr = '0;
	logic [APB_DW-1:0]       pwdata = '0;
	logic [APB_DW-1:0]       prdata;
	logic                    pready;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic [CH_W-1:0]         channel = '0;
	logic signed [RAW_W-1:0] raw_sample = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [CH_W-1:0]         out_channel;
	logic signed [Q_W-1:0]   filtered_value;

	multichannel_sensor_moving_average u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.channel(channel),
		.raw_sample(raw_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_channel(out_channel),
		.filtered_value(filtered_value)
	);

	always #10 clk = ~clk;

	sample_t   pending_samples[$];
	average_t  expected_averages[$];
	msma_cfg_t model_cfg;
	logic signed [Q_W-1:0] model_ring[CHANNELS_DEF][WINDOW_DEF];
	longint    model_sum[CHANNELS_DEF];
	int        model_pos[CHANNELS_DEF];
	int        model_fill[CHANNELS_DEF];

	int  queued_count = 0;
	int  accepted_count = 0;
	int  fail_count = 0;
	int  cycle_count = 0;
	logic in_fire = 1'b0;
	int  burst_left = 1;
	int  gap_left = 0;
	int  rx_mode = 0;
	int  rx_left = 0;
	int  rx_phase = 0;

	function automatic logic signed [Q_W-1:0] clamp_q(input longint v);
		if (v > 64'sd8388607) begin
			return 24'sh7FFFFF;
		end
		if (v < -64'sd8388608) begin
			return 24'sh800000;
		end
		return v[Q_W-1:0];
	endfunction

	function automatic logic signed [Q_W-1:0] scale_sample(input logic [CH_W-1:0] ch,
		input logic signed [RAW_W-1:0] raw);
		logic [GAIN_W-1:0]     gain;
		longint                prod;
		logic signed [Q_W-1:0] scaled;
		if (ch < CH_GYRO_FIRST) begin
			gain = model_cfg.accel_gain;
		end else if (ch < CH_TEMP) begin
			gain = model_cfg.gyro_gain;
		end else begin
			gain = model_cfg.temp_gain;
		end
		prod = longint'(raw) * longint'(gain);
		scaled = clamp_q((prod + 64'sd32768) >>> FRAC_SHIFT);
		if (ch == CH_TEMP) begin
			scaled = clamp_q(longint'(scaled) + longint'(model_cfg.temp_offset));
		end
		return scaled;
	endfunction

	task automatic update_average(input logic [CH_W-1:0] ch, input logic signed [RAW_W-1:0] raw);
		logic signed [Q_W-1:0] scaled;
		average_t              avg_item;
		int                    c;
		if (ch >= CHANNELS_DEF) begin
			return;
		end
		c = ch;
		scaled = scale_sample(ch, raw);
		model_sum[c] = model_sum[c] - longint'(model_ring[c][model_pos[c]]) + longint'(scaled);
		model_ring[c][model_pos[c]] = scaled;
		model_pos[c] = (model_pos[c] + 1) % WINDOW_DEF;
		if (model_fill[c] < WINDOW_DEF) begin
			model_fill[c]++;
		end
		avg_item.ch = ch;
		avg_item.avg = Q_W'(model_sum[c] / longint'(model_fill[c]));
		expected_averages.push_back(avg_item);
	endtask

	task automatic queue_sample(input logic [CH_W-1:0] ch, input logic signed [RAW_W-1:0] raw);
		sample_t s;
		s.ch = ch;
		s.raw = raw;
		pending_samples.push_back(s);
		queued_count++;
	endtask

	function automatic logic signed [RAW_W-1:0] pick_raw();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2: return RAW_W'($urandom_range(0, 3)) - 16'sd1;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic queue_random(input int count);
		int               n;
		logic [CH_W-1:0]  ch;
		n = 0;
		while (n < count) begin
			ch = ($urandom_range(0, 24) == 0) ? CH_NONE : CH_W'($urandom_range(0, CHANNELS_DEF - 1));
			queue_sample(ch, pick_raw());
			if (ch != CH_NONE) begin
				n++;
			end
		end
	endtask

	task automatic wait_drained();
		while (accepted_count != queued_count || expected_averages.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [Q_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {{(APB_DW - Q_W){1'b0}}, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) begin
			@(posedge clk);
		end
		case (idx)
			REG_ACCEL_GAIN:  model_cfg.accel_gain = value;
			REG_GYRO_GAIN:   model_cfg.gyro_gain = value;
			REG_TEMP_GAIN:   model_cfg.temp_gain = value;
			REG_TEMP_OFFSET: model_cfg.temp_offset = value;
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic write_all(input logic [GAIN_W-1:0] ag, input logic [GAIN_W-1:0] gg,
		input logic [GAIN_W-1:0] tg, input logic [Q_W-1:0] ofs);
		write_reg(REG_ACCEL_GAIN, ag);
		write_reg(REG_GYRO_GAIN, gg);
		write_reg(REG_TEMP_GAIN, tg);
		write_reg(REG_TEMP_OFFSET, ofs);
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_fire) begin
			in_valid <= 1'b1;
		end else if (gap_left > 0) begin
			in_valid <= 1'b0;
			gap_left--;
		end else if (pending_samples.size() > 0) begin
			in_valid <= 1'b1;
			channel <= pending_samples[0].ch;
			raw_sample <= pending_samples[0].raw;
			pending_samples.delete(0);
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 12);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
			end
		end else begin
			in_valid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (rx_left <= 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_left = $urandom_range(20, 200);
		end
		rx_left--;
		rx_phase++;
		case (rx_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= $urandom_range(0, 1);
			2: out_ready <= (rx_phase % 8) == 0;
			default: out_ready <= (rx_phase % 3) != 0;
		endcase
	end

	always @(posedge clk) begin
		in_fire <= in_valid && in_ready;
		if (in_valid && in_ready) begin
			accepted_count++;
			update_average(channel, raw_sample);
		end
		if (out_valid && out_ready) begin
			if (expected_averages.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_MAX) begin
					$display("unexpected result: channel %0d value %0d", out_channel,
						filtered_value);
				end
			end else begin
				if (out_channel != expected_averages[0].ch
					|| filtered_value != expected_averages[0].avg) begin
					fail_count++;
					if (fail_count <= REPORT_MAX) begin
						$display("mismatch: expected channel %0d value %0d, got channel %0d value %0d",
							expected_averages[0].ch, expected_averages[0].avg, out_channel,
							filtered_value);
					end
				end
				expected_averages.delete(0);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("multichannel_sensor_moving_average test failed");
			$finish;
		end
	end

	initial begin
		model_cfg.accel_gain = ACCEL_GAIN_RST;
		model_cfg.gyro_gain = GYRO_GAIN_RST;
		model_cfg.temp_gain = TEMP_GAIN_RST;
		model_cfg.temp_offset = TEMP_OFFSET_RST;
		for (int c = 0; c < CHANNELS_DEF; c++) begin
			for (int i = 0; i < WINDOW_DEF; i++) begin
				model_ring[c][i] = '0;
			end
			model_sum[c] = 0;
			model_pos[c] = 0;
			model_fill[c] = 0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int c = 0; c < CHANNELS_DEF; c++) begin
			queue_sample(CH_W'(c), 16'sh7FFF);
			queue_sample(CH_W'(c), 16'sh8000);
		end
		queue_sample(CH_NONE, 16'sh7FFF);
		queue_sample(CH_NONE, 16'sh8000);
		queue_sample(CH_TEMP, 16'sd0);
		queue_sample(3'd0, -16'sd1);
		queue_sample(3'd0, 16'sd1);
		queue_sample(CH_GYRO_FIRST, 16'sh5555);
		queue_sample(3'd5, 16'shAAAA);
		queue_sample(CH_TEMP, 16'sh7FFF);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		write_all(24'h000000, 24'h000000, 24'h000000, 24'h800000);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		write_all(24'hFFFFFF, 24'h000001, 24'hFFFFFF, 24'h800000);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		write_all(GAIN_W'($urandom), GAIN_W'($urandom), GAIN_W'($urandom), Q_W'($urandom));
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		write_all(ACCEL_GAIN_RST, GYRO_GAIN_RST, TEMP_GAIN_RST, TEMP_OFFSET_RST);
		queue_random(RANDOM_PER_PHASE);
		wait_drained();

		if (fail_count == 0) begin
			$display("multichannel_sensor_moving_average test passed");
		end else begin
			$display("multichannel_sensor_moving_average test failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
